/* sv/rlec_pkg.sv */
// Shared types, codes and constants of the RGB LED effect controller.
package rlec_pkg;

  // Fixed field widths.
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned COLOR_W    = 3 * DUTY_W;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 32;

  // Default breathing period in milliseconds.
  localparam int unsigned BREATH_PERIOD_DEF = 2000;

  // Breathing unit sequencing: one reciprocal multiply step, then one channel per step.
  localparam int unsigned QUO_W         = DUTY_W;
  localparam int unsigned DIV_STEPS     = 1;
  localparam int unsigned MUL_STEPS     = 3;
  localparam int unsigned STEP_W        = 2;
  localparam int unsigned STEP_MUL_LAST = DIV_STEPS + MUL_STEPS - 1;

  typedef enum logic [MODE_W-1:0] {
    MD_TICK   = 3'd0,
    MD_OFF    = 3'd1,
    MD_STEADY = 3'd2,
    MD_SOLID  = 3'd3,
    MD_BLINK  = 3'd4,
    MD_PULSE  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    EF_OFF       = 3'd0,
    EF_STEADY    = 3'd1,
    EF_SOLID     = 3'd2,
    EF_BLINK_ON  = 3'd3,
    EF_BLINK_OFF = 3'd4,
    EF_PULSE     = 3'd5
  } effect_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_BREATH,
    CT_OUT
  } ctl_t;

  // One decoded command word. Color packs red in the top byte.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COLOR_W-1:0] color;
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Answer of the breathing unit.
  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] duty;
  } breath_rsp_t;

endpackage

/* sv/rlec_breath.sv */
// Breathing unit: ramp scale by reciprocal multiply, then a shared 8x8 multiply per channel.
module rlec_breath import rlec_pkg::*; #(
  parameter int unsigned BREATH_PERIOD_MS = BREATH_PERIOD_DEF,
  localparam int unsigned PH_W = $clog2(BREATH_PERIOD_MS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PH_W-1:0]    phase,
  input  logic [COLOR_W-1:0] color,
  output breath_rsp_t        rsp
);

  localparam int unsigned D_W   = $clog2(BREATH_PERIOD_MS + 1);
  localparam int unsigned NUM_W = D_W + 9;
  // Rounded-up reciprocal of the period; exact floor division for any NUM_W-bit numerator.
  localparam int unsigned     SHIFT = NUM_W + PH_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(BREATH_PERIOD_MS) - 64'd1) / 64'(BREATH_PERIOD_MS);
  localparam int unsigned     R_W   = $clog2(RECIP + 64'd1);

  logic               run;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [NUM_W-1:0]   numer;
  logic [QUO_W-1:0]   quo;
  logic [COLOR_W-1:0] duty;

  logic [D_W:0]         two_p;
  logic [D_W-1:0]       ramp_dist;
  logic [NUM_W-1:0]     num;
  logic [NUM_W+R_W-1:0] scaled;
  logic [1:0]           chan;
  logic [DUTY_W-1:0]    chan_color;
  logic [2*DUTY_W-1:0]  product;

  // Distance to the nearest end of the ramp; the numerator is 510 times that.
  always_comb begin
    two_p = (D_W + 1)'(phase) << 1;
    if (two_p < (D_W + 1)'(BREATH_PERIOD_MS)) begin
      ramp_dist = D_W'(phase);
    end else begin
      ramp_dist = D_W'(BREATH_PERIOD_MS) - D_W'(phase);
    end
    num = (NUM_W'(ramp_dist) << 9) - (NUM_W'(ramp_dist) << 1);
  end

  assign scaled = (NUM_W + R_W)'(numer) * (NUM_W + R_W)'(RECIP);
  assign chan   = 2'(step - STEP_W'(DIV_STEPS));

  always_comb begin
    unique case (chan)
      2'd0:    chan_color = color[3*DUTY_W-1:2*DUTY_W];
      2'd1:    chan_color = color[2*DUTY_W-1:DUTY_W];
      default: chan_color = color[DUTY_W-1:0];
    endcase
    product = chan_color * quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEP_MUL_LAST)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numer <= num;
    end else if (run) begin
      if (step < STEP_W'(DIV_STEPS)) begin
        quo <= scaled[SHIFT +: QUO_W];
      end else begin
        unique case (chan)
          2'd0:    duty[3*DUTY_W-1:2*DUTY_W] <= product[2*DUTY_W-1:DUTY_W];
          2'd1:    duty[2*DUTY_W-1:DUTY_W]   <= product[2*DUTY_W-1:DUTY_W];
          2'd2:    duty[DUTY_W-1:0]          <= product[2*DUTY_W-1:DUTY_W];
          default: ;
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.duty = duty;

endmodule

/* sv/rlec_effect.sv */
// Effect state: command decode, tick-counted phases, blink bookkeeping and breathing phase.
module rlec_effect import rlec_pkg::*; #(
  parameter int unsigned BREATH_PERIOD_MS = BREATH_PERIOD_DEF,
  localparam int unsigned PH_W = $clog2(BREATH_PERIOD_MS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               apply,
  input  cmd_t               cmd,
  input  breath_rsp_t        rsp,
  output logic               want_breath,
  output logic [PH_W-1:0]    phase,
  output logic [COLOR_W-1:0] held_color,
  output logic [COLOR_W-1:0] shown_duty,
  output logic               busy
);

  effect_t            state, state_next;
  logic [COLOR_W-1:0] held_color_next, shown_duty_next;
  logic [TIME_W-1:0]  time_left, time_left_next;
  logic [COUNT_W-1:0] blinks_left, blinks_left_next;
  logic [TIME_W-1:0]  saved_on, saved_on_next;
  logic [TIME_W-1:0]  saved_off, saved_off_next;
  logic [PH_W-1:0]    phase_next;
  logic               phase_end;
  logic [COUNT_W-1:0] blinks_dec;
  mode_t              mode;

  assign mode       = mode_t'(cmd.mode);
  assign phase_end  = (time_left[TIME_W-1:1] == '0);
  assign blinks_dec = blinks_left - 1'b1;

  // A pulse command, or a tick while breathing, needs a new breathing duty.
  assign want_breath = (mode == MD_PULSE) || ((mode == MD_TICK) && (state == EF_PULSE));

  always_comb begin
    state_next       = state;
    held_color_next  = held_color;
    shown_duty_next  = shown_duty;
    time_left_next   = time_left;
    blinks_left_next = blinks_left;
    saved_on_next    = saved_on;
    saved_off_next   = saved_off;
    phase_next       = phase;
    if (apply) begin
      unique case (mode)
        MD_TICK: begin
          unique case (state)
            EF_SOLID: begin
              time_left_next = phase_end ? '0 : time_left - 1'b1;
              if (phase_end) begin
                shown_duty_next = '0;
                state_next      = EF_OFF;
              end
            end
            EF_BLINK_ON: begin
              time_left_next = phase_end ? '0 : time_left - 1'b1;
              if (phase_end) begin
                shown_duty_next  = '0;
                blinks_left_next = blinks_dec;
                if (blinks_dec == '0) begin
                  state_next = EF_OFF;
                end else begin
                  state_next     = EF_BLINK_OFF;
                  time_left_next = saved_off;
                end
              end
            end
            EF_BLINK_OFF: begin
              time_left_next = phase_end ? '0 : time_left - 1'b1;
              if (phase_end) begin
                shown_duty_next = held_color;
                state_next      = EF_BLINK_ON;
                time_left_next  = saved_on;
              end
            end
            EF_PULSE: begin
              phase_next = (phase == PH_W'(BREATH_PERIOD_MS - 1)) ? '0 : phase + 1'b1;
            end
            default: ;
          endcase
        end
        MD_OFF: begin
          state_next      = EF_OFF;
          shown_duty_next = '0;
        end
        MD_STEADY: begin
          state_next      = EF_STEADY;
          shown_duty_next = cmd.color;
        end
        MD_SOLID: begin
          state_next      = EF_SOLID;
          shown_duty_next = cmd.color;
          time_left_next  = cmd.on_ms;
        end
        MD_BLINK: begin
          if (cmd.count == '0) begin
            state_next = EF_STEADY;
          end else begin
            state_next       = EF_BLINK_ON;
            held_color_next  = cmd.color;
            shown_duty_next  = cmd.color;
            blinks_left_next = cmd.count;
            saved_on_next    = cmd.on_ms;
            saved_off_next   = cmd.off_ms;
            time_left_next   = cmd.on_ms;
          end
        end
        MD_PULSE: begin
          if ((state != EF_PULSE) || (held_color != cmd.color)) begin
            state_next      = EF_PULSE;
            held_color_next = cmd.color;
            phase_next      = '0;
          end
        end
        default: ;
      endcase
    end else if (rsp.done) begin
      shown_duty_next = rsp.duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= EF_OFF;
      held_color  <= '0;
      shown_duty  <= '0;
      time_left   <= '0;
      blinks_left <= '0;
      saved_on    <= '0;
      saved_off   <= '0;
      phase       <= '0;
    end else begin
      state       <= state_next;
      held_color  <= held_color_next;
      shown_duty  <= shown_duty_next;
      time_left   <= time_left_next;
      blinks_left <= blinks_left_next;
      saved_on    <= saved_on_next;
      saved_off   <= saved_off_next;
      phase       <= phase_next;
    end
  end

  assign busy = (state == EF_SOLID) || (state == EF_BLINK_ON) || (state == EF_BLINK_OFF);

endmodule

/* sv/rgb_led_effect_controller.sv */
// Top level of the RGB LED effect controller: handshake sequencer, effect state and breathing unit.
// A word that needs no breathing duty is offered as a result in the cycle after acceptance;
// no new word is taken until that result is taken. Off, steady, timed solid, blink and ticks outside
// breathing take this path. A pulse command or a tick while breathing waits for the breathing unit
// to finish its steps, one reciprocal multiply and 3 channel multiplies, before its result is offered.
// Reset (rst, synchronous): effect off, shown duty and timers zero, no result pending.
module rgb_led_effect_controller import rlec_pkg::*; #(
  parameter int unsigned BREATH_PERIOD_MS = BREATH_PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // From bit 0: red[8], green[8], blue[8], on_ms[24], off_ms[24], blink_count[8].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Bits: mode[3].
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0: duty_red[8], duty_green[8], duty_blue[8], busy_res[1], zero pad[7].
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned PH_W = $clog2(BREATH_PERIOD_MS);

  ctl_t               ctl, ctl_next;
  logic               breath_go;
  logic               accept;
  cmd_t               cmd;
  breath_rsp_t        rsp;
  logic               want_breath;
  logic [PH_W-1:0]    phase;
  logic [COLOR_W-1:0] held_color;
  logic [COLOR_W-1:0] shown_duty;
  logic               busy;

  assign accept = s_tvalid && s_tready;

  // The command word keeps red in the top byte of the color, as the duty register does.
  assign cmd.mode   = s_tuser;
  assign cmd.color  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
  assign cmd.on_ms  = s_tdata[47:24];
  assign cmd.off_ms = s_tdata[71:48];
  assign cmd.count  = s_tdata[79:72];

  // Next-state logic of the word sequencer. A breathing word waits for the unit to finish.
  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CT_IDLE: begin
        if (s_tvalid) begin
          ctl_next = want_breath ? CT_BREATH : CT_OUT;
        end
      end
      CT_BREATH: begin
        if (rsp.done) begin
          ctl_next = CT_OUT;
        end
      end
      CT_OUT: begin
        if (m_tready) begin
          ctl_next = CT_IDLE;
        end
      end
      default: ctl_next = CT_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (ctl)
      CT_IDLE: s_tready = 1'b1;
      CT_OUT:  m_tvalid = 1'b1;
      default: ;
    endcase
  end

  // The breathing unit is started in the cycle after acceptance, once the phase and the
  // held color have taken the values of the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= CT_IDLE;
      breath_go <= 1'b0;
    end else begin
      ctl       <= ctl_next;
      breath_go <= accept && want_breath;
    end
  end

  rlec_effect #(
    .BREATH_PERIOD_MS(BREATH_PERIOD_MS)
  ) u_effect (
    .clk         (clk),
    .rst         (rst),
    .apply       (accept),
    .cmd         (cmd),
    .rsp         (rsp),
    .want_breath (want_breath),
    .phase       (phase),
    .held_color  (held_color),
    .shown_duty  (shown_duty),
    .busy        (busy)
  );

  rlec_breath #(
    .BREATH_PERIOD_MS(BREATH_PERIOD_MS)
  ) u_breath (
    .clk   (clk),
    .rst   (rst),
    .start (breath_go),
    .phase (phase),
    .color (held_color),
    .rsp   (rsp)
  );

  // The effect registers hold still while a result is offered, so the word is stable.
  assign m_tdata = {7'b0, busy, shown_duty[DUTY_W-1:0], shown_duty[2*DUTY_W-1:DUTY_W],
                    shown_duty[3*DUTY_W-1:2*DUTY_W]};

endmodule
